// ----- rtl/servo_bus_command_engine_defines.svh -----
// Assertion macros shared by the servo bus command engine RTL.
`ifndef SERVO_BUS_COMMAND_ENGINE_DEFINES_SVH
`define SERVO_BUS_COMMAND_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SBCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sbce: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define SBCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sbce: next-cycle check failed");

`endif

// ----- rtl/sbce_pkg.sv -----
// Types, codes and helper functions of the servo bus command engine.
`timescale 1ns / 1ps

package sbce_pkg;

    // request function codes
    localparam logic [1:0] FUNC_CMD = 2'd0;
    localparam logic [1:0] FUNC_RX  = 2'd1;
    localparam logic [1:0] FUNC_TMO = 2'd2;

    // command operations
    localparam logic [2:0] OP_PING  = 3'd0;
    localparam logic [2:0] OP_RD_B  = 3'd1;
    localparam logic [2:0] OP_RD_W  = 3'd2;
    localparam logic [2:0] OP_WR_B  = 3'd3;
    localparam logic [2:0] OP_WR_W  = 3'd4;
    localparam logic [2:0] OP_RESET = 3'd5;

    // result kinds and verdicts
    localparam logic       KIND_TX      = 1'b0;
    localparam logic       KIND_VERDICT = 1'b1;
    localparam logic [1:0] VERD_OK      = 2'd0;
    localparam logic [1:0] VERD_MISM    = 2'd1;
    localparam logic [1:0] VERD_DEV_ERR = 2'd2;
    localparam logic [1:0] VERD_TMO     = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_HDR1     = 3'd0;
    localparam logic [2:0] CFG_HDR2     = 3'd1;
    localparam logic [2:0] CFG_OP_PING  = 3'd2;
    localparam logic [2:0] CFG_OP_READ  = 3'd3;
    localparam logic [2:0] CFG_OP_WRITE = 3'd4;
    localparam logic [2:0] CFG_OP_RESET = 3'd5;

    // frame length field values
    localparam logic [7:0] LEN_NO_PARAM  = 8'd2;
    localparam logic [7:0] LEN_TWO_PARAM = 8'd4;
    localparam logic [7:0] LEN_WR_WORD   = 8'd5;

    // expected reply lengths
    localparam logic [3:0] RPL_LEN_BASE = 4'd6;
    localparam logic [3:0] RPL_LEN_RD_B = 4'd7;
    localparam logic [3:0] RPL_LEN_RD_W = 4'd8;

    localparam int REPLY_DEPTH = 8;

    typedef struct packed {
        logic [7:0] hdr1;
        logic [7:0] hdr2;
        logic [7:0] op_ping;
        logic [7:0] op_read;
        logic [7:0] op_write;
        logic [7:0] op_reset;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  op;
        logic [7:0]  target_id;
        logic [7:0]  ctl_addr;
        logic [15:0] write_value;
        logic [7:0]  rx_byte;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [1:0]  verdict;
        logic [7:0]  error_status;
        logic [15:0] read_value;
    } t_result;

    // control from the sequencer to the reply tracker
    typedef struct packed {
        logic       cmd_load;
        logic       rx_load;
        logic       tmo_load;
        logic [2:0] op;
        logic [7:0] id;
        logic [7:0] rx_byte;
    } t_trk_ctrl;

    // status from the reply tracker
    typedef struct packed {
        logic        waiting;
        logic        rx_done;
        logic [1:0]  verdict;
        logic [7:0]  error_status;
        logic [15:0] read_value;
    } t_trk_stat;

    // number of request frame bytes for an operation
    function automatic logic [3:0] frame_len(input logic [2:0] op);
        logic [3:0] len;
        case (op)
            OP_RD_B, OP_RD_W, OP_WR_B: len = 4'd8;
            OP_WR_W:                   len = 4'd9;
            default:                   len = 4'd6;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/sbce_if.sv -----
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps

interface sbce_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [2:0]  op;
    logic [7:0]  target_id;
    logic [7:0]  ctl_addr;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;

    modport source (output valid, func, op, target_id, ctl_addr, write_value, rx_byte,
                    input ready);
    modport sink (input valid, func, op, target_id, ctl_addr, write_value, rx_byte,
                  output ready);
endinterface

interface sbce_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  verdict;
    logic [7:0]  error_status;
    logic [15:0] read_value;

    modport source (output valid, kind, tx_byte, last, verdict, error_status, read_value,
                    input ready);
    modport sink (input valid, kind, tx_byte, last, verdict, error_status, read_value,
                  output ready);
endinterface

// ----- rtl/sbce_frame_gen.sv -----
// Request frame byte selection and checksum.
`timescale 1ns / 1ps

module sbce_frame_gen
    import sbce_pkg::*;
(
    input  t_item      i_item,
    input  t_cfg       i_cfg,
    input  logic [3:0] i_idx,
    output logic [7:0] o_tx_byte,
    output logic       o_last
);

    logic [7:0] len_byte;
    logic [7:0] opc;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic       no_param;
    logic       two_param;
    logic [7:0] chk;

    always_comb begin
        len_byte  = LEN_TWO_PARAM;
        opc       = i_cfg.op_read;
        p0        = i_item.ctl_addr;
        p1        = 8'd0;
        p2        = 8'd0;
        no_param  = 1'b0;
        two_param = 1'b1;
        case (i_item.op)
            OP_PING: begin
                len_byte = LEN_NO_PARAM;
                opc      = i_cfg.op_ping;
                p0       = 8'd0;
                no_param = 1'b1;
            end
            OP_RD_B: begin
                p1 = 8'd1;
            end
            OP_RD_W: begin
                p1 = 8'd2;
            end
            OP_WR_B: begin
                opc = i_cfg.op_write;
                p1  = i_item.write_value[7:0];
            end
            OP_WR_W: begin
                len_byte  = LEN_WR_WORD;
                opc       = i_cfg.op_write;
                p1        = i_item.write_value[7:0];
                p2        = i_item.write_value[15:8];
                two_param = 1'b0;
            end
            default: begin
                len_byte = LEN_NO_PARAM;
                opc      = i_cfg.op_reset;
                p0       = 8'd0;
                no_param = 1'b1;
            end
        endcase
        chk = ~(i_item.target_id + len_byte + opc + p0 + p1 + p2);
    end

    always_comb begin
        case (i_idx)
            4'd0:    o_tx_byte = i_cfg.hdr1;
            4'd1:    o_tx_byte = i_cfg.hdr2;
            4'd2:    o_tx_byte = i_item.target_id;
            4'd3:    o_tx_byte = len_byte;
            4'd4:    o_tx_byte = opc;
            4'd5:    o_tx_byte = no_param ? chk : p0;
            4'd6:    o_tx_byte = p1;
            4'd7:    o_tx_byte = two_param ? chk : p2;
            4'd8:    o_tx_byte = chk;
            default: o_tx_byte = 8'd0;
        endcase
    end

    assign o_last = (i_idx == frame_len(i_item.op) - 4'd1);

endmodule

// ----- rtl/sbce_reply_trk.sv -----
// Pending transaction state, reply byte store and verdict logic.
`timescale 1ns / 1ps

module sbce_reply_trk
    import sbce_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_trk_ctrl i_ctrl,
    input  t_cfg      i_cfg,
    output t_trk_stat o_stat
);

    logic       r_waiting;
    logic [2:0] r_pend_op;
    logic [7:0] r_pend_id;
    logic [3:0] r_exp_len;
    logic [3:0] r_rx_count;
    logic [7:0] r_reply [REPLY_DEPTH];
    logic [3:0] n_rx_count;

    assign n_rx_count = r_rx_count + 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting  <= 1'b0;
            r_pend_op  <= OP_PING;
            r_pend_id  <= 8'd0;
            r_exp_len  <= 4'd0;
            r_rx_count <= 4'd0;
        end else if (i_ctrl.cmd_load) begin
            r_waiting  <= 1'b1;
            r_pend_op  <= i_ctrl.op;
            r_pend_id  <= i_ctrl.id;
            r_rx_count <= 4'd0;
            case (i_ctrl.op)
                OP_RD_B: r_exp_len <= RPL_LEN_RD_B;
                OP_RD_W: r_exp_len <= RPL_LEN_RD_W;
                default: r_exp_len <= RPL_LEN_BASE;
            endcase
        end else if (i_ctrl.rx_load && r_waiting) begin
            r_rx_count <= n_rx_count;
            if (o_stat.rx_done) begin
                r_waiting <= 1'b0;
            end
        end else if (i_ctrl.tmo_load) begin
            r_waiting <= 1'b0;
        end
    end

    // reply store: no reset, entries are read only after being written
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rx_load && r_waiting && !r_rx_count[3]) begin
            r_reply[r_rx_count[2:0]] <= i_ctrl.rx_byte;
        end
    end

    always_comb begin
        o_stat.waiting      = r_waiting;
        o_stat.rx_done      = r_waiting && (n_rx_count >= r_exp_len);
        o_stat.verdict      = VERD_OK;
        o_stat.error_status = 8'd0;
        o_stat.read_value   = 16'd0;
        if (r_reply[0] != i_cfg.hdr1 || r_reply[1] != i_cfg.hdr2 ||
            r_reply[2] != r_pend_id) begin
            o_stat.verdict = VERD_MISM;
        end else begin
            o_stat.error_status = r_reply[4];
            if (r_pend_op != OP_PING && r_reply[4] != 8'd0) begin
                o_stat.verdict = VERD_DEV_ERR;
            end else if (r_pend_op == OP_RD_B) begin
                o_stat.read_value = {8'd0, r_reply[5]};
            end else if (r_pend_op == OP_RD_W) begin
                o_stat.read_value = {r_reply[6], r_reply[5]};
            end
        end
    end

endmodule

// ----- rtl/servo_bus_command_engine.sv -----
// Top level of the servo bus command engine: input register, sequencer, result register.
// Master side of a half-duplex smart-servo bus. Each request on i_cmd is one of: a command
// (ping, read byte, read word, write byte, write word, factory reset), one byte received
// from the bus, or a response timeout. A command produces its whole request frame on o_res,
// one transmit byte per result (two header bytes, id, length, instruction, parameters,
// inverted 8-bit checksum of id onward), with last set on the checksum byte. Received bytes
// are collected until the reply length of the pending command is reached (6 bytes, 7 for a
// read byte, 8 for a read word); the engine then emits one verdict with the reply's error
// byte and any read data. Reply checksums are not checked. A timeout while waiting ends the
// transaction with a timeout verdict. A new command abandons a pending one without a verdict.
// Bytes and timeouts while idle, unknown ops and unknown function codes produce nothing.
// Rate: received bytes, timeouts and ignored requests leave the input register as they step,
// so a new request is accepted every cycle while no verdict waits on a stalled result sink;
// a command holds the input register until its last frame byte is emitted, one frame byte
// per result, as the result register takes one result a cycle while the sink is ready.
// Configuration writes on i_cfg_* take effect at the next edge and belong in idle periods.
`timescale 1ns / 1ps
`include "servo_bus_command_engine_defines.svh"

module servo_bus_command_engine
    import sbce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    sbce_cmd_if.sink   i_cmd,
    sbce_res_if.source o_res
);

    // configuration registers
    t_cfg       r_cfg;

    // input register and frame byte index
    logic       r_in_valid;
    t_item      r_in;
    logic [3:0] r_idx;

    // result register
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;

    logic       in_is_cmd;
    logic       in_is_rx;
    logic       in_is_tmo;
    logic       has_result;
    logic       can_emit;
    logic       step;
    logic       retire;
    logic       emit;
    logic [7:0] frame_byte;
    logic       frame_last;
    t_trk_ctrl  trk_ctrl;
    t_trk_stat  trk_stat;

    // Hold register writes; unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr1     <= 8'hFF;
            r_cfg.hdr2     <= 8'hFF;
            r_cfg.op_ping  <= 8'd1;
            r_cfg.op_read  <= 8'd2;
            r_cfg.op_write <= 8'd3;
            r_cfg.op_reset <= 8'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HDR1:     r_cfg.hdr1     <= i_cfg_data;
                CFG_HDR2:     r_cfg.hdr2     <= i_cfg_data;
                CFG_OP_PING:  r_cfg.op_ping  <= i_cfg_data;
                CFG_OP_READ:  r_cfg.op_read  <= i_cfg_data;
                CFG_OP_WRITE: r_cfg.op_write <= i_cfg_data;
                CFG_OP_RESET: r_cfg.op_reset <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Classify the held request against the current transaction state.
    assign in_is_cmd  = (r_in.func == FUNC_CMD) && (r_in.op inside {[OP_PING:OP_RESET]});
    assign in_is_rx   = (r_in.func == FUNC_RX) && trk_stat.waiting;
    assign in_is_tmo  = (r_in.func == FUNC_TMO) && trk_stat.waiting;
    assign has_result = in_is_cmd || (in_is_rx && trk_stat.rx_done) || in_is_tmo;

    // Advance when the result register has room, or at once when nothing comes out.
    assign can_emit = !r_out_valid || o_res.ready;
    assign step     = r_in_valid && (!has_result || can_emit);
    assign emit     = step && has_result;
    assign retire   = step && (!in_is_cmd || frame_last);

    assign i_cmd.ready = !r_in_valid || retire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_idx      <= 4'd0;
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                r_in_valid <= 1'b1;
            end else if (retire) begin
                r_in_valid <= 1'b0;
            end
            if (retire) begin
                r_idx <= 4'd0;
            end else if (step && in_is_cmd) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in.func        <= i_cmd.func;
            r_in.op          <= i_cmd.op;
            r_in.target_id   <= i_cmd.target_id;
            r_in.ctl_addr    <= i_cmd.ctl_addr;
            r_in.write_value <= i_cmd.write_value;
            r_in.rx_byte     <= i_cmd.rx_byte;
        end
    end

    sbce_frame_gen u_frame_gen (
        .i_item    (r_in),
        .i_cfg     (r_cfg),
        .i_idx     (r_idx),
        .o_tx_byte (frame_byte),
        .o_last    (frame_last)
    );

    // Commit the transaction state once per request: a command on its last byte.
    always_comb begin
        trk_ctrl.cmd_load = retire && in_is_cmd;
        trk_ctrl.rx_load  = step && in_is_rx;
        trk_ctrl.tmo_load = step && in_is_tmo;
        trk_ctrl.op       = r_in.op;
        trk_ctrl.id       = r_in.target_id;
        trk_ctrl.rx_byte  = r_in.rx_byte;
    end

    sbce_reply_trk u_reply_trk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (trk_ctrl),
        .i_cfg   (r_cfg),
        .o_stat  (trk_stat)
    );

    // Build the next result: frame byte, reply verdict or timeout verdict.
    always_comb begin
        n_out.kind         = KIND_VERDICT;
        n_out.tx_byte      = 8'd0;
        n_out.last         = 1'b0;
        n_out.verdict      = VERD_TMO;
        n_out.error_status = 8'd0;
        n_out.read_value   = 16'd0;
        if (in_is_cmd) begin
            n_out.kind    = KIND_TX;
            n_out.tx_byte = frame_byte;
            n_out.last    = frame_last;
            n_out.verdict = VERD_OK;
        end else if (in_is_rx) begin
            n_out.verdict      = trk_stat.verdict;
            n_out.error_status = trk_stat.error_status;
            n_out.read_value   = trk_stat.read_value;
        end
    end

    // Hold the result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out.kind;
    assign o_res.tx_byte      = r_out.tx_byte;
    assign o_res.last         = r_out.last;
    assign o_res.verdict      = r_out.verdict;
    assign o_res.error_status = r_out.error_status;
    assign o_res.read_value   = r_out.read_value;

    // The byte index never runs past the frame of the held command.
    `SBCE_ASSERT_IMPL(a_idx_in_frame, i_clk, i_rst_n, r_in_valid && in_is_cmd, r_idx < frame_len(r_in.op))
    // A verdict closes the transaction.
    `SBCE_ASSERT_NEXT(a_verdict_ends_wait, i_clk, i_rst_n, emit && !in_is_cmd, !trk_stat.waiting)
    // Finishing a frame rewinds the byte index and leaves the engine waiting.
    `SBCE_ASSERT_NEXT(a_frame_rewinds, i_clk, i_rst_n, retire && in_is_cmd, r_idx == 4'd0 && trk_stat.waiting)

endmodule

// ----- bench/sbce_frame_checker.sv -----
// Checker for the servo bus command engine: mirrors its state and compares every result.
`timescale 1ns / 1ps

module sbce_frame_checker
    import sbce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    sbce_cmd_if        i_cmd,
    sbce_res_if        i_res,
    output int         o_mismatches,
    output int         o_owed
);

    t_cfg       cfg;
    logic       waiting;
    logic [2:0] pend_op;
    logic [7:0] pend_id;
    logic [3:0] reply_len;
    logic [3:0] rx_cnt;
    logic [7:0] reply_buf [REPLY_DEPTH];

    // frames and verdicts the engine still owes, oldest first
    t_result    owed_results [$];
    int         mismatch_count = 0;

    logic [7:0] frame [9];
    int         frame_n;
    logic [7:0] csum;
    logic [15:0] rd_val;
    t_result    got;
    t_result    want;

    function automatic t_result verdict_result(input logic [1:0] v, input logic [7:0] err,
                                               input logic [15:0] rv);
        t_result r;
        r = '0;
        r.kind = KIND_VERDICT;
        r.verdict = v;
        r.error_status = err;
        r.read_value = rv;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] exp_val,
                                          input logic [15:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg = '{hdr1: 8'hFF, hdr2: 8'hFF, op_ping: 8'h01, op_read: 8'h02,
                    op_write: 8'h03, op_reset: 8'h06};
            waiting = 1'b0;
            pend_op = OP_PING;
            pend_id = '0;
            reply_len = '0;
            rx_cnt = '0;
            foreach (reply_buf[k]) reply_buf[k] = '0;
            owed_results.delete();
        end else begin
            // results first: nothing accepted at this edge can already have an answer
            if (i_res.valid && i_res.ready) begin
                got.kind = i_res.kind;
                got.tx_byte = i_res.tx_byte;
                got.last = i_res.last;
                got.verdict = i_res.verdict;
                got.error_status = i_res.error_status;
                got.read_value = i_res.read_value;
                if (owed_results.size() == 0) begin
                    $error("unexpected result: kind %0d tx_byte 0x%0h verdict %0d",
                           got.kind, got.tx_byte, got.verdict);
                    mismatch_count++;
                end else begin
                    want = owed_results.pop_front();
                    compare_field("kind", want.kind, got.kind);
                    compare_field("tx_byte", want.tx_byte, got.tx_byte);
                    compare_field("last", want.last, got.last);
                    compare_field("verdict", want.verdict, got.verdict);
                    compare_field("error_status", want.error_status, got.error_status);
                    compare_field("read_value", want.read_value, got.read_value);
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HDR1:     cfg.hdr1 = i_cfg_data;
                    CFG_HDR2:     cfg.hdr2 = i_cfg_data;
                    CFG_OP_PING:  cfg.op_ping = i_cfg_data;
                    CFG_OP_READ:  cfg.op_read = i_cfg_data;
                    CFG_OP_WRITE: cfg.op_write = i_cfg_data;
                    CFG_OP_RESET: cfg.op_reset = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.valid && i_cmd.ready) begin
                case (i_cmd.func)
                    FUNC_CMD: begin
                        frame[0] = cfg.hdr1;
                        frame[1] = cfg.hdr2;
                        frame[2] = i_cmd.target_id;
                        case (i_cmd.op)
                            OP_PING, OP_RESET: begin
                                frame[3] = LEN_NO_PARAM;
                                frame[4] = (i_cmd.op == OP_PING) ? cfg.op_ping : cfg.op_reset;
                                frame_n = 5;
                            end
                            OP_RD_B, OP_RD_W: begin
                                frame[3] = LEN_TWO_PARAM;
                                frame[4] = cfg.op_read;
                                frame[5] = i_cmd.ctl_addr;
                                frame[6] = (i_cmd.op == OP_RD_B) ? 8'd1 : 8'd2;
                                frame_n = 7;
                            end
                            OP_WR_B: begin
                                frame[3] = LEN_TWO_PARAM;
                                frame[4] = cfg.op_write;
                                frame[5] = i_cmd.ctl_addr;
                                frame[6] = i_cmd.write_value[7:0];
                                frame_n = 7;
                            end
                            OP_WR_W: begin
                                frame[3] = LEN_WR_WORD;
                                frame[4] = cfg.op_write;
                                frame[5] = i_cmd.ctl_addr;
                                frame[6] = i_cmd.write_value[7:0];
                                frame[7] = i_cmd.write_value[15:8];
                                frame_n = 8;
                            end
                            default: frame_n = 0;
                        endcase
                        // unknown ops leave everything as it was
                        if (frame_n != 0) begin
                            csum = '0;
                            for (int k = 2; k < frame_n; k++) csum += frame[k];
                            frame[frame_n] = ~csum;
                            frame_n++;
                            for (int k = 0; k < frame_n; k++) begin
                                want = '0;
                                want.kind = KIND_TX;
                                want.tx_byte = frame[k];
                                want.last = (k == frame_n - 1);
                                owed_results.push_back(want);
                            end
                            waiting = 1'b1;
                            pend_op = i_cmd.op;
                            pend_id = i_cmd.target_id;
                            reply_len = (i_cmd.op == OP_RD_B) ? RPL_LEN_RD_B :
                                        (i_cmd.op == OP_RD_W) ? RPL_LEN_RD_W : RPL_LEN_BASE;
                            rx_cnt = '0;
                        end
                    end
                    FUNC_RX: begin
                        if (waiting) begin
                            if (rx_cnt < REPLY_DEPTH) reply_buf[rx_cnt] = i_cmd.rx_byte;
                            rx_cnt = rx_cnt + 4'd1;
                            if (rx_cnt >= reply_len) begin
                                waiting = 1'b0;
                                if (reply_buf[0] != cfg.hdr1 || reply_buf[1] != cfg.hdr2 ||
                                    reply_buf[2] != pend_id) begin
                                    owed_results.push_back(verdict_result(VERD_MISM, '0, '0));
                                end else if (pend_op != OP_PING && reply_buf[4] != 8'h00) begin
                                    owed_results.push_back(
                                        verdict_result(VERD_DEV_ERR, reply_buf[4], '0));
                                end else begin
                                    rd_val = '0;
                                    if (pend_op == OP_RD_B) rd_val = {8'h00, reply_buf[5]};
                                    else if (pend_op == OP_RD_W)
                                        rd_val = {reply_buf[6], reply_buf[5]};
                                    owed_results.push_back(
                                        verdict_result(VERD_OK, reply_buf[4], rd_val));
                                end
                            end
                        end
                    end
                    FUNC_TMO: begin
                        if (waiting) begin
                            waiting = 1'b0;
                            owed_results.push_back(verdict_result(VERD_TMO, '0, '0));
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_owed <= owed_results.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// ----- bench/servo_bus_command_engine_test.sv -----
// Top of the servo bus command engine bench: clock, reset, requests, result pacing, verdict.
`timescale 1ns / 1ps

module servo_bus_command_engine_test;
    import sbce_pkg::*;

    localparam int HALF_PERIOD   = 10;
    // cycles to let an engine with nothing owed finish internal work (longest frame is 9)
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 240;
    localparam int PHASES        = 5;

    // codes the engine has no meaning for
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [2:0] OP_BAD_A    = 3'd6;
    localparam logic [2:0] OP_BAD_B    = 3'd7;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = CFG_HDR1;
    logic [7:0] i_cfg_data = 8'h00;

    sbce_cmd_if cmd_ch ();
    sbce_res_if res_ch ();

    int   mismatches;
    int   owed;

    // header bytes currently loaded, used to build well-formed replies
    t_cfg bus_cfg;

    // pacing of both sides; a burst flag turns the random gaps off for a stretch
    logic tx_burst = 1'b0;
    logic rx_burst = 1'b0;
    int   rx_hold = 0;
    logic res_ready = 1'b0;
    int   counted_items = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    assign res_ch.ready = res_ready;

    servo_bus_command_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch)
    );

    sbce_frame_checker frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_mismatches (mismatches),
        .o_owed       (owed)
    );

    // Result sink: after each accepted result, drop ready for a random hold (none in a burst).
    // Flip into and out of a no-stall stretch now and then.
    always @(posedge i_clk) begin : sink_pace
        int hold;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
            rx_hold <= 0;
        end else if (res_ch.valid && res_ch.ready) begin
            if ($urandom_range(0, 39) == 0) rx_burst <= ~rx_burst;
            hold = rx_burst ? 0 : $urandom_range(0, 4);
            rx_hold <= hold;
            res_ready <= (hold == 0);
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            res_ready <= (rx_hold == 1);
        end else begin
            res_ready <= 1'b1;
        end
    end

    // Fill every field at random; callers overwrite what matters for the request.
    function automatic t_item random_fill(input logic [1:0] func);
        t_item it;
        it.func = func;
        it.op = 3'($urandom_range(0, 7));
        it.target_id = 8'($urandom_range(0, 255));
        it.ctl_addr = 8'($urandom_range(0, 255));
        it.write_value = 16'($urandom_range(0, 65535));
        it.rx_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Present one request and hold it until accepted. Enter and leave at a rising edge;
    // valid stays high on exit so back-to-back requests never drop it within a step.
    task automatic push_request(input t_item it);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func <= it.func;
        cmd_ch.op <= it.op;
        cmd_ch.target_id <= it.target_id;
        cmd_ch.ctl_addr <= it.ctl_addr;
        cmd_ch.write_value <= it.write_value;
        cmd_ch.rx_byte <= it.rx_byte;
        do @(posedge i_clk); while (!cmd_ch.ready);
        if (it.func == FUNC_RX || it.func == FUNC_TMO ||
            (it.func == FUNC_CMD && it.op <= OP_RESET))
            counted_items++;
    endtask

    task automatic issue_cmd(input logic [2:0] op, input logic [7:0] id,
                             input logic [7:0] addr, input logic [15:0] value);
        t_item it;
        it = random_fill(FUNC_CMD);
        it.op = op;
        it.target_id = id;
        it.ctl_addr = addr;
        it.write_value = value;
        push_request(it);
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_item it;
        it = random_fill(FUNC_RX);
        it.rx_byte = b;
        push_request(it);
    endtask

    // Feed the first count bytes of a reply frame. Flip masks spoil the headers or the id;
    // the length and checksum bytes are never looked at, so fill them with noise.
    task automatic send_reply(input logic [7:0] id,
                              input logic [7:0] err, input logic [15:0] data,
                              input logic [15:0] hdr_flip, input logic [7:0] id_flip,
                              input int count);
        logic [7:0] reply [8];
        reply[0] = bus_cfg.hdr1 ^ hdr_flip[7:0];
        reply[1] = bus_cfg.hdr2 ^ hdr_flip[15:8];
        reply[2] = id ^ id_flip;
        reply[3] = 8'($urandom_range(0, 255));
        reply[4] = err;
        reply[5] = data[7:0];
        reply[6] = data[15:8];
        reply[7] = 8'($urandom_range(0, 255));
        for (int k = 0; k < count; k++) send_byte(reply[k]);
    endtask

    function automatic int reply_span(input logic [2:0] op);
        return (op == OP_RD_B) ? int'(RPL_LEN_RD_B) :
               (op == OP_RD_W) ? int'(RPL_LEN_RD_W) : int'(RPL_LEN_BASE);
    endfunction

    // Stop sending and hold off until every owed result is in, then let the engine settle.
    // The first edge comes before the check so that requests of this step are counted.
    task automatic wait_quiet();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (owed != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [7:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    initial begin
        t_cfg       phase_cfg;
        t_item      it;
        int         r;
        int         target;
        logic [2:0] op;
        logic [7:0] id;
        logic [7:0] err;
        logic [15:0] hdr_flip;
        logic [7:0] id_flip;

        cmd_ch.valid = 1'b0;
        cmd_ch.func = FUNC_CMD;
        cmd_ch.op = OP_PING;
        cmd_ch.target_id = 8'h00;
        cmd_ch.ctl_addr = 8'h00;
        cmd_ch.write_value = 16'h0000;
        cmd_ch.rx_byte = 8'h00;
        bus_cfg = '{hdr1: 8'hFF, hdr2: 8'hFF, op_ping: 8'h01, op_read: 8'h02,
                    op_write: 8'h03, op_reset: 8'h06};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset configuration.
        // Requests an idle engine must ignore: unknown op, stray byte, stray timeout,
        // unused function code.
        it = random_fill(FUNC_CMD);
        it.op = OP_BAD_B;
        push_request(it);
        send_byte(8'hFF);
        push_request(random_fill(FUNC_TMO));
        push_request(random_fill(FUNC_UNUSED));

        // Extreme fields; each new command abandons the one before, the last times out.
        issue_cmd(OP_WR_W, 8'hFF, 8'hFF, 16'hFFFF);
        issue_cmd(OP_WR_B, 8'h00, 8'h00, 16'h0000);
        issue_cmd(OP_RESET, 8'h7F, 8'h80, 16'h8000);
        push_request(random_fill(FUNC_TMO));

        // Ping with an error byte still passes; read word with all-ones data;
        // read byte with an error byte is a device error.
        issue_cmd(OP_PING, 8'h01, 8'h00, 16'h0000);
        send_reply(8'h01, 8'hFF, 16'h0000, 16'h0000, 8'h00, reply_span(OP_PING));
        issue_cmd(OP_RD_W, 8'hFE, 8'h80, 16'h0000);
        send_reply(8'hFE, 8'h00, 16'hFFFF, 16'h0000, 8'h00, reply_span(OP_RD_W));
        issue_cmd(OP_RD_B, 8'h10, 8'h3C, 16'h0000);
        send_reply(8'h10, 8'h80, 16'h00A5, 16'h0000, 8'h00, reply_span(OP_RD_B));

        // Random part: one configuration per phase, the extremes first.
        counted_items = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: phase_cfg = '0;
                1: phase_cfg = '1;
                default: begin
                    phase_cfg.hdr1 = 8'($urandom_range(0, 255));
                    phase_cfg.hdr2 = 8'($urandom_range(0, 255));
                    phase_cfg.op_ping = 8'($urandom_range(0, 255));
                    phase_cfg.op_read = 8'($urandom_range(0, 255));
                    phase_cfg.op_write = 8'($urandom_range(0, 255));
                    phase_cfg.op_reset = 8'($urandom_range(0, 255));
                end
            endcase

            // Registers change only on an idle engine.
            wait_quiet();
            cfg_write(CFG_HDR1, phase_cfg.hdr1);
            cfg_write(CFG_HDR2, phase_cfg.hdr2);
            cfg_write(CFG_OP_PING, phase_cfg.op_ping);
            cfg_write(CFG_OP_READ, phase_cfg.op_read);
            cfg_write(CFG_OP_WRITE, phase_cfg.op_write);
            cfg_write(CFG_OP_RESET, phase_cfg.op_reset);
            i_cfg_we <= 1'b0;
            bus_cfg = phase_cfg;

            target = (phase + 1) * RANDOM_ITEMS / PHASES;
            while (counted_items < target) begin
                tx_burst = ($urandom_range(0, 4) == 0);
                r = $urandom_range(0, 99);
                op = 3'($urandom_range(0, 5));
                id = 8'($urandom_range(0, 255));

                if (r < 88)
                    issue_cmd(op, id, 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)));

                if (r < 62) begin
                    // Complete reply; now and then spoil a header or the id,
                    // and often report a device error.
                    hdr_flip = '0;
                    id_flip = '0;
                    case ($urandom_range(0, 11))
                        0: hdr_flip[7:0] = 8'($urandom_range(1, 255));
                        1: hdr_flip[15:8] = 8'($urandom_range(1, 255));
                        2: id_flip = 8'($urandom_range(1, 255));
                        default: ;
                    endcase
                    err = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                    send_reply(id, err, 16'($urandom_range(0, 65535)), hdr_flip, id_flip,
                               reply_span(op));
                end else if (r < 72) begin
                    // Reply cut short, then the response timer fires.
                    send_reply(id, 8'h00, 16'($urandom_range(0, 65535)), '0, '0,
                               $urandom_range(0, reply_span(op) - 1));
                    push_request(random_fill(FUNC_TMO));
                end else if (r < 84) begin
                    // Reply cut short and abandoned by whatever command comes next.
                    send_reply(id, 8'h00, 16'($urandom_range(0, 65535)), '0, '0,
                               $urandom_range(0, reply_span(op) - 1));
                end else if (r < 88) begin
                    push_request(random_fill(FUNC_TMO));
                end else if (r < 91) begin
                    wait_quiet();
                end else begin
                    case ($urandom_range(0, 3))
                        0: begin
                            it = random_fill(FUNC_CMD);
                            it.op = ($urandom_range(0, 1) == 0) ? OP_BAD_A : OP_BAD_B;
                        end
                        1: it = random_fill(FUNC_RX);
                        2: it = random_fill(FUNC_TMO);
                        default: it = random_fill(FUNC_UNUSED);
                    endcase
                    push_request(it);
                end
            end
        end

        tx_burst = 1'b0;
        wait_quiet();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- servo_bus_command_engine.f -----
+incdir+rtl
rtl/sbce_pkg.sv
rtl/sbce_if.sv
rtl/sbce_frame_gen.sv
rtl/sbce_reply_trk.sv
rtl/servo_bus_command_engine.sv
bench/sbce_frame_checker.sv
bench/servo_bus_command_engine_test.sv
